>>> src/tnk_pkg.sv
// ============================================================================
// tnk_pkg: shared types and constants of the top-N key tracker
// Entry record layout, request opcodes and the cell control bundle.
// ============================================================================
package tnk_pkg;

    localparam int ID_W    = 22;
    localparam int KEY_W   = 48;
    localparam int TICK_W  = 48;
    localparam int RANK_W  = 3;

    localparam logic OP_OFFER  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [KEY_W-1:0]  key;
        logic [TICK_W-1:0] user_ticks;
        logic [TICK_W-1:0] sys_ticks;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;      // offer accepted: insert candidate
        logic shift_up;  // emit step: every cell takes its lower neighbor
    } cell_ctrl_t;

endpackage

>>> src/top_n_by_key_tracker_unit.sv
// ============================================================================
// top_n_by_key_tracker_unit: keeps the TOP_N records with the largest key
// Systolic insertion chain in descending key order; a finish request reads
// the list out in rank order and leaves it empty.
// ============================================================================
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  request   | start & !busy           | opcode, cand_id, cand_key,
//            |                         | cand_user_ticks, cand_sys_ticks
//  result    | result_strobe (1 cycle) | rank, entry_valid, out_id, out_key,
//            |                         | out_user_ticks, out_sys_ticks, last
//
//  Offer: busy stays low, so offers may arrive every cycle unless a finish
//    readout holds busy. All cells compare against the broadcast
//    candidate at once; insertion point and shift-down settle with the offer.
//  Finish: busy high while the readout runs, low again by the last
//    result; one result per cycle, first result in the cycle after the
//    request. The readout shifts the chain up one cell per cycle, so its
//    length is set by the entry count.
//  Reset clears the entry count and the controller; cell contents are
//    not reset and are only read below the count.
//  The receiver cannot stall: results are presented once, back to back.
//
module top_n_by_key_tracker_unit #(
    parameter int TOP_N    = 5,
    parameter int KEY_BITS = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [tnk_pkg::ID_W-1:0]      cand_id,
    input  logic [tnk_pkg::KEY_W-1:0]     cand_key,
    input  logic [tnk_pkg::TICK_W-1:0]    cand_user_ticks,
    input  logic [tnk_pkg::TICK_W-1:0]    cand_sys_ticks,
    // result side
    output logic                          result_strobe,
    output logic [tnk_pkg::RANK_W-1:0]    rank,
    output logic                          entry_valid,
    output logic [tnk_pkg::ID_W-1:0]      out_id,
    output logic [tnk_pkg::KEY_W-1:0]     out_key,
    output logic [tnk_pkg::TICK_W-1:0]    out_user_ticks,
    output logic [tnk_pkg::TICK_W-1:0]    out_sys_ticks,
    output logic                          last
);
    import tnk_pkg::*;

    localparam int CNT_W = $clog2(TOP_N + 1);
    // keys compare on their low KEY_BITS bits, never more than the field holds
    localparam int CMP_BITS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_W'(1) << CMP_BITS) - KEY_W'(1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TOP_N);

    // controller state
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rank_cnt_reg, rank_cnt_next;

    logic              strobe_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              valid_reg;
    logic              last_reg;
    entry_t            out_entry_reg;

    logic              offer_go;
    logic              emit_go;
    logic              emit_last;
    entry_t            cand;
    cell_ctrl_t        ctrl;

    entry_t            cell_entry [TOP_N];
    logic              cell_take  [TOP_N];

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    assign busy     = (state_reg == ST_EMIT);
    assign offer_go = start && !busy && (opcode == OP_OFFER);
    // first readout step runs in the cycle the finish request is taken
    assign emit_go  = busy || (start && (opcode == OP_FINISH));
    // empty list gives a single marker, so count of 0 or 1 ends the run
    assign emit_last = (count_reg <= CNT_W'(1));

    assign cand.id         = cand_id;
    assign cand.key        = cand_key & KEY_MASK;
    assign cand.user_ticks = cand_user_ticks;
    assign cand.sys_ticks  = cand_sys_ticks;

    assign ctrl.load     = offer_go;
    assign ctrl.shift_up = emit_go;

    // ------------------------------------------------------------------
    // cell chain: cell 0 holds the largest key
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < TOP_N; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
            logic   occ;
            logic   prev_take;
            entry_t prev_entry;
            entry_t next_entry;

            assign occ = (IDX < count_reg);

            if (gi == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_entry = cand;
            end
            else
            begin : g_body
                assign prev_take  = cell_take[gi-1];
                assign prev_entry = cell_entry[gi-1];
            end

            if (gi == TOP_N - 1)
            begin : g_tail
                // shifted-in content is beyond the count and never read
                assign next_entry = cell_entry[gi];
            end
            else
            begin : g_link
                assign next_entry = cell_entry[gi+1];
            end

            tnk_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ),
                .cand       (cand),
                .prev_take  (prev_take),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .take       (cell_take[gi]),
                .entry      (cell_entry[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rank_cnt_next = rank_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (offer_go && (count_reg != FULL_CNT))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (emit_go && !emit_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit_go)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            rank_cnt_next = emit_last ? '0 : rank_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rank_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rank_cnt_reg <= rank_cnt_next;
            strobe_reg   <= emit_go;
        end
    end

    // result register: head cell, or all-zero marker on an empty list
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            rank_reg  <= RANK_W'(rank_cnt_reg);
            valid_reg <= (count_reg != '0);
            last_reg  <= emit_last;
            out_entry_reg <= (count_reg != '0) ? cell_entry[0] : '0;
        end
    end

    assign result_strobe  = strobe_reg;
    assign rank           = rank_reg;
    assign entry_valid    = valid_reg;
    assign out_id         = out_entry_reg.id;
    assign out_key        = out_entry_reg.key;
    assign out_user_ticks = out_entry_reg.user_ticks;
    assign out_sys_ticks  = out_entry_reg.sys_ticks;
    assign last           = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above list depth");

    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=> result_strobe)
        else $error("readout run broken before last result");

    a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |-> !busy)
        else $error("still busy after last result");

    generate
        for (gi = 0; gi + 1 < TOP_N; gi++)
        begin : g_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (CNT_W'(gi + 1) < count_reg) |->
                    (cell_entry[gi].key >= cell_entry[gi+1].key))
                else $error("ranked list out of order");
        end
    endgenerate

endmodule

>>> src/tnk_cell.sv
// ============================================================================
// tnk_cell: one slot of the ranked list
// Compares the broadcast candidate against its own key, hands its record
// down on insertion and up on readout.
// ============================================================================
module tnk_cell (
    input  logic                clk,
    input  tnk_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  tnk_pkg::entry_t     cand,
    input  logic                prev_take,
    input  tnk_pkg::entry_t     prev_entry,
    input  tnk_pkg::entry_t     next_entry,
    output logic                take,
    output tnk_pkg::entry_t     entry
);
    import tnk_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // list is sorted, so take is monotonic along the chain
    assign take  = !occupied || (cand.key > entry_reg.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_up)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.load)
        begin
            if (prev_take)
            begin
                entry_next = prev_entry;
            end
            else if (take)
            begin
                entry_next = cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
